// File: hw/rtl/wfc_pkg.sv
// Shared types and constants for the waveform classifier.
package wfc_pkg;

   localparam int unsigned SampleWidth  = 10;
   localparam int unsigned StampWidth   = 32;
   localparam int unsigned FreqWidth    = 24;
   localparam int unsigned CsrIdxWidth  = 4;
   localparam int unsigned WindowDefault = 10;

   // Sixteenths of a hertz per microsecond of period
   localparam logic [FreqWidth-1:0] TicksQ4 = 24'd16000000;

   localparam logic [SampleWidth-1:0] SampleMax = 10'd1023;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_CROSSING_LEVEL = 4'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_ABRUPT_LEVEL   = 4'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_SMOOTH_LEVEL   = 4'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_SLOPE_LEVEL    = 4'd3;

   localparam logic [SampleWidth-1:0] CrossingReset = 10'd511;
   localparam logic [SampleWidth-1:0] AbruptReset   = 10'd205;
   localparam logic [SampleWidth-1:0] SmoothReset   = 10'd61;
   localparam logic [SampleWidth-1:0] SlopeReset    = 10'd41;

   typedef enum logic [1:0] {
      CLASS_SQUARE   = 2'd0,
      CLASS_SINE     = 2'd1,
      CLASS_TRIANGLE = 2'd2,
      CLASS_UNKNOWN  = 2'd3
   } wave_class_type;

   // Step thresholds handed to the window scanner
   typedef struct packed {
      logic [SampleWidth-1:0] abrupt;
      logic [SampleWidth-1:0] smooth;
      logic [SampleWidth-1:0] slope;
   } levels_type;

endpackage

// File: hw/rtl/wfc_div.sv
// Restoring divider: one quotient bit a cycle of the fixed tick count by a period.
module wfc_div import wfc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [StampWidth-1:0] divisor,
   output logic                  busy,
   output logic [FreqWidth-1:0]  quotient
);

   localparam int unsigned BitWidth = $clog2(FreqWidth);

   logic                  busy_ff, busy_in;
   logic [BitWidth-1:0]   bit_ff, bit_in;
   logic [StampWidth-1:0] dvs_ff, dvs_in;
   logic [StampWidth-1:0] rem_ff, rem_in;
   logic [FreqWidth-1:0]  quo_ff, quo_in;
   logic [StampWidth:0]   trial;
   logic [StampWidth:0]   diff;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, TicksQ4[bit_ff]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      bit_in  = bit_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = BitWidth'(FreqWidth - 1);
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[StampWidth-1:0] : trial[StampWidth-1:0];
         quo_in = {quo_ff[FreqWidth-2:0], fits};
         bit_in = bit_ff - 1'b1;
         if (bit_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      bit_ff <= bit_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   // The partial remainder always stays below the divisor
   a_rem_below_divisor : assert property (@(posedge clock) disable iff (reset)
      busy_ff && !$past(start) |-> rem_ff < dvs_ff)
      else $error("divider remainder not below divisor");

endmodule

// File: hw/rtl/wfc_scan.sv
// Window scanner: walks the sample window oldest first, one entry a cycle.
module wfc_scan import wfc_pkg::*; #(
   parameter int unsigned WINDOW = WindowDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [$clog2(WINDOW)-1:0]    start_slot,
   input  levels_type                   levels,
   output logic [$clog2(WINDOW)-1:0]    rd_idx,
   input  logic [SampleWidth-1:0]       rd_data,
   output logic                         busy,
   output wave_class_type               wave_class
);

   localparam int unsigned IdxWidth = $clog2(WINDOW);
   localparam int unsigned CntWidth = $clog2(WINDOW + 1);
   localparam int unsigned AbrWidth = $clog2(WINDOW);
   localparam int unsigned Half     = WINDOW / 2;

   logic                          busy_ff, busy_in;
   logic [CntWidth-1:0]           cnt_ff, cnt_in;
   logic [IdxWidth-1:0]           idx_ff, idx_in;
   logic [SampleWidth-1:0]        prev_ff, prev_in;
   logic signed [SampleWidth:0]   pd_ff, pd_in;
   logic [AbrWidth-1:0]           abr_ff, abr_in;
   logic                          smooth_ff, smooth_in;
   logic                          steady_ff, steady_in;
   wave_class_type                class_ff, class_in;

   logic signed [SampleWidth:0]   step;
   logic signed [SampleWidth+1:0] bend;
   logic [SampleWidth-1:0]        step_mag;
   logic [SampleWidth:0]          bend_mag;

   always_comb begin
      step     = $signed({1'b0, rd_data}) - $signed({1'b0, prev_ff});
      bend     = $signed({step[SampleWidth], step}) - $signed({pd_ff[SampleWidth], pd_ff});
      step_mag = step[SampleWidth] ? SampleWidth'(-step) : step[SampleWidth-1:0];
      bend_mag = bend[SampleWidth+1] ? (SampleWidth+1)'(-bend) : bend[SampleWidth:0];
   end

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      prev_in   = prev_ff;
      pd_in     = pd_ff;
      abr_in    = abr_ff;
      smooth_in = smooth_ff;
      steady_in = steady_ff;
      class_in  = class_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         idx_in    = start_slot;
         abr_in    = '0;
         smooth_in = 1'b1;
         steady_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff < CntWidth'(WINDOW)) begin
            prev_in = rd_data;
            idx_in  = (idx_ff == IdxWidth'(WINDOW - 1)) ? '0 : idx_ff + 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               pd_in = step;
               if (step_mag > levels.abrupt) begin
                  abr_in = abr_ff + 1'b1;
               end
               if (step_mag > levels.smooth) begin
                  smooth_in = 1'b0;
               end
               if (cnt_ff > CntWidth'(1) && bend_mag > {1'b0, levels.slope}) begin
                  steady_in = 1'b0;
               end
            end
         end else begin
            // all entries seen: settle the class
            busy_in = 1'b0;
            priority if (abr_ff > AbrWidth'(Half)) begin
               class_in = CLASS_SQUARE;
            end else if (smooth_ff) begin
               class_in = CLASS_SINE;
            end else if (steady_ff) begin
               class_in = CLASS_TRIANGLE;
            end else begin
               class_in = CLASS_UNKNOWN;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff    <= cnt_in;
      idx_ff    <= idx_in;
      prev_ff   <= prev_in;
      pd_ff     <= pd_in;
      abr_ff    <= abr_in;
      smooth_ff <= smooth_in;
      steady_ff <= steady_in;
      class_ff  <= class_in;
   end

   assign rd_idx     = idx_ff;
   assign busy       = busy_ff;
   assign wave_class = class_ff;

   a_cnt_in_range : assert property (@(posedge clock) disable iff (reset)
      busy_ff && !$past(start) |-> cnt_ff <= CntWidth'(WINDOW) && idx_ff < IdxWidth'(WINDOW))
      else $error("scan counter or index out of range");

endmodule

// File: hw/rtl/waveform_classifier.sv
// Waveform classifier top level: sample state, sequencer and result register.
// A request transfer starts the window scan and, when it marks a crossing with a nonzero
// interval, the period divider; the two run in parallel and the result is then registered.
// No new item is taken until the last one is through, which is put off while a finished result waits.
// A waiting result is held in the output register while the next item is worked on.
// Synchronous reset restores the default levels, zeroes the window and clears extrema.
module waveform_classifier import wfc_pkg::*; #(
   parameter int unsigned WINDOW = WindowDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SampleWidth-1:0] req_sample,
   input  logic [StampWidth-1:0]  req_stamp_us,
   input  logic                   req_clear_extrema,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SampleWidth-1:0] rsp_amplitude,
   output logic [1:0]             rsp_wave_class,
   output logic [FreqWidth-1:0]   rsp_frequency_q4,
   input  logic                   csr_wen,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [SampleWidth-1:0] csr_wdata
);

   localparam int unsigned IdxWidth = $clog2(WINDOW);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [SampleWidth-1:0] cross_lvl_ff;
   levels_type             levels_ff;
   logic [SampleWidth-1:0] window_ff [WINDOW];
   logic [IdxWidth-1:0]    slot_ff, slot_in;
   logic [SampleWidth-1:0] max_ff, max_in;
   logic [SampleWidth-1:0] min_ff, min_in;
   logic [SampleWidth-1:0] prior_ff;
   logic [StampWidth-1:0]  cross_time_ff;
   logic [FreqWidth-1:0]   freq_ff;
   logic                   div_used_ff;
   logic                   rsp_valid_ff;
   logic [SampleWidth-1:0] amp_ff;
   wave_class_type         class_out_ff;
   logic [FreqWidth-1:0]   freq_out_ff;

   logic                   accept;
   logic                   crossed;
   logic [StampWidth-1:0]  dt;
   logic                   div_start;
   logic                   finish;
   logic [SampleWidth-1:0] max_base, min_base;
   logic [FreqWidth-1:0]   freq_next;
   logic [IdxWidth-1:0]    scan_idx;
   logic                   scan_busy, div_busy;
   wave_class_type         scan_class;
   logic [FreqWidth-1:0]   div_quot;

   assign accept = req_valid && req_ready;

   always_comb begin
      crossed = (prior_ff > cross_lvl_ff && req_sample <= cross_lvl_ff) ||
                (prior_ff < cross_lvl_ff && req_sample >= cross_lvl_ff);
      dt        = req_stamp_us - cross_time_ff;
      div_start = accept && crossed && (dt != '0);
      slot_in   = (slot_ff == IdxWidth'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
      max_base  = req_clear_extrema ? '0 : max_ff;
      min_base  = req_clear_extrema ? SampleMax : min_ff;
      max_in    = (req_sample > max_base) ? req_sample : max_base;
      min_in    = (req_sample < min_base) ? req_sample : min_base;
      freq_next = div_used_ff ? div_quot : freq_ff;
   end

   // Leave the busy state once both units are done and the output stage is free
   assign finish = (state_ff == ST_BUSY) && !scan_busy && !div_busy &&
                   (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         cross_lvl_ff  <= CrossingReset;
         levels_ff     <= '{abrupt: AbruptReset, smooth: SmoothReset, slope: SlopeReset};
         slot_ff       <= '0;
         max_ff        <= '0;
         min_ff        <= SampleMax;
         prior_ff      <= '0;
         cross_time_ff <= '0;
         freq_ff       <= '0;
         div_used_ff   <= 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            window_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            unique case (csr_index)
               CSR_CROSSING_LEVEL: cross_lvl_ff     <= csr_wdata;
               CSR_ABRUPT_LEVEL:   levels_ff.abrupt <= csr_wdata;
               CSR_SMOOTH_LEVEL:   levels_ff.smooth <= csr_wdata;
               CSR_SLOPE_LEVEL:    levels_ff.slope  <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            window_ff[slot_ff] <= req_sample;
            slot_ff            <= slot_in;
            max_ff             <= max_in;
            min_ff             <= min_in;
            prior_ff           <= req_sample;
            div_used_ff        <= div_start;
            if (crossed) begin
               cross_time_ff <= req_stamp_us;
            end
         end
         if (finish) begin
            freq_ff <= freq_next;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (finish) begin
         amp_ff       <= (max_ff >= min_ff) ? max_ff - min_ff : '0;
         class_out_ff <= scan_class;
         freq_out_ff  <= freq_next;
      end
   end

   wfc_scan #(
      .WINDOW(WINDOW)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .start_slot (slot_in),
      .levels     (levels_ff),
      .rd_idx     (scan_idx),
      .rd_data    (window_ff[scan_idx]),
      .busy       (scan_busy),
      .wave_class (scan_class)
   );

   wfc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (dt),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // Refuse transfers while reset is held
   assign req_ready        = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_amplitude    = amp_ff;
   assign rsp_wave_class   = class_out_ff;
   assign rsp_frequency_q4 = freq_out_ff;

   a_units_idle_when_ready : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !scan_busy && !div_busy)
      else $error("unit busy while accepting requests");

   a_result_from_busy : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_BUSY) && state_ff == ST_IDLE)
      else $error("result raised outside completion");

   a_freq_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_frequency_q4 <= TicksQ4)
      else $error("frequency above bound");

endmodule
